@@ rtl/mips_subset_execute_unit_defines.svh @@
// Assertion macros shared by the execute unit RTL.
`ifndef MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSEU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSEU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mseu_pkg.sv @@
// Types and constants of the MIPS subset execute unit.
`timescale 1ns / 1ps
`default_nettype none
package mseu_pkg;

    localparam int MEM_BYTES_DEF = 1024;
    localparam logic [4:0] REG_LINK = 5'd31;

    typedef enum logic [4:0] {
        K_ADD, K_ADDU, K_SUB, K_AND, K_OR, K_XOR, K_NOR, K_NAND,
        K_SLT, K_SLL, K_SRL, K_SRA, K_ADDI, K_ADDIU, K_LW, K_LH,
        K_LHU, K_LB, K_LBU, K_SW, K_SH, K_SB, K_LUI, K_ANDI,
        K_ORI, K_NORI, K_SLTI, K_BEQ, K_BNE, K_BGTZ, K_J, K_JAL
    } t_kind;

    typedef enum logic [1:0] {
        SZ_BYTE, SZ_HALF, SZ_WORD
    } t_size;

    typedef struct packed {
        logic        rf_we;
        logic [4:0]  rf_waddr;
        logic [31:0] rf_wdata;
        logic        mem_rd;
        logic        mem_wr;
        t_size       size;
        logic [31:0] addr;
        logic [31:0] next_pc;
        logic        e_zero;
        logic        e_ovf;
        logic        e_addr;
        logic        e_align;
    } t_exec;

endpackage
`default_nettype wire

@@ rtl/mseu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mseu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/mseu_alu.sv @@
// Execute logic: ALU, shifts, compares, address and next-PC, error flags.
`timescale 1ns / 1ps
`default_nettype none
module mseu_alu
    import mseu_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  t_kind        i_kind,
    input  wire  [4:0]   i_rt_index,
    input  wire  [4:0]   i_rd_index,
    input  wire  [4:0]   i_shift_amount,
    input  wire  [15:0]  i_immediate,
    input  wire  [25:0]  i_jump_target,
    input  wire  [31:0]  i_pc,
    input  wire  [31:0]  i_a,
    input  wire  [31:0]  i_b,
    output t_exec        o_ex
);
    localparam logic [31:0] LIM_B = 32'(MEM_BYTES - 1);
    localparam logic [31:0] LIM_H = 32'(MEM_BYTES - 2);
    localparam logic [31:0] LIM_W = 32'(MEM_BYTES - 4);

    logic [31:0] imm_s, imm_z, opb, sum, diff, pc4, br_tgt, jmp_tgt, res;
    logic        ovf_add, ovf_sub, lt, is_r, is_load, is_store, ok;

    assign imm_s   = {{16{i_immediate[15]}}, i_immediate};
    assign imm_z   = {16'h0000, i_immediate};
    assign is_r    = (i_kind <= K_SRA);
    assign opb     = is_r ? i_b : imm_s;
    assign sum     = i_a + opb;
    assign diff    = i_a - i_b;
    assign ovf_add = ((i_a[31] ^ sum[31]) & (opb[31] ^ sum[31]));
    assign ovf_sub = ((i_a[31] ^ i_b[31]) & (i_a[31] ^ diff[31]));
    assign lt      = ($signed(i_a) < $signed(opb));
    assign pc4     = i_pc + 32'd4;
    assign br_tgt  = pc4 + {imm_s[29:0], 2'b00};
    assign jmp_tgt = {pc4[31:28], i_jump_target, 2'b00};
    assign is_load  = (i_kind >= K_LW) && (i_kind <= K_LBU);
    assign is_store = (i_kind >= K_SW) && (i_kind <= K_SB);

    always_comb begin
        o_ex         = '0;
        o_ex.next_pc = pc4;
        o_ex.addr    = sum;
        o_ex.size    = SZ_BYTE;
        res          = '0;
        ok           = 1'b0;
        unique case (i_kind) inside
            K_ADD:   begin res = sum; o_ex.e_ovf = ovf_add; end
            K_ADDU:  res = sum;
            K_SUB:   begin res = diff; o_ex.e_ovf = ovf_sub; end
            K_AND:   res = i_a & i_b;
            K_OR:    res = i_a | i_b;
            K_XOR:   res = i_a ^ i_b;
            K_NOR:   res = ~(i_a | i_b);
            K_NAND:  res = ~(i_a & i_b);
            K_SLT:   res = {31'd0, lt};
            K_SLL:   res = i_b << i_shift_amount;
            K_SRL:   res = i_b >> i_shift_amount;
            K_SRA:   res = 32'($signed(i_b) >>> i_shift_amount);
            K_ADDI:  begin res = sum; o_ex.e_ovf = ovf_add; end
            K_ADDIU: res = sum;
            K_LUI:   res = {i_immediate, 16'h0000};
            K_ANDI:  res = i_a & imm_z;
            K_ORI:   res = i_a | imm_z;
            K_NORI:  res = ~(i_a | imm_z);
            K_SLTI:  res = {31'd0, lt};
            K_BEQ:   if (i_a == i_b) o_ex.next_pc = br_tgt;
            K_BNE:   if (i_a != i_b) o_ex.next_pc = br_tgt;
            K_BGTZ:  if (!i_a[31] && (i_a != '0)) o_ex.next_pc = br_tgt;
            K_J:     o_ex.next_pc = jmp_tgt;
            K_JAL:   begin o_ex.next_pc = jmp_tgt; res = pc4; end
            default: res = '0; // loads and stores
        endcase

        if (is_r) begin
            // sll with all fields zero is the nop and is exempt
            o_ex.e_zero   = (i_rd_index == '0) &&
                            !((i_kind == K_SLL) && (i_rt_index == '0) &&
                              (i_shift_amount == '0));
            o_ex.rf_we    = !o_ex.e_zero;
            o_ex.rf_waddr = i_rd_index;
        end else if (is_load || is_store) begin
            o_ex.e_ovf = ovf_add;
            if ((i_kind == K_LW) || (i_kind == K_SW)) begin
                o_ex.size    = SZ_WORD;
                o_ex.e_addr  = sum[31] || (sum > LIM_W);
                o_ex.e_align = (sum[1:0] != 2'b00);
            end else if ((i_kind == K_LH) || (i_kind == K_LHU) || (i_kind == K_SH)) begin
                o_ex.size    = SZ_HALF;
                o_ex.e_addr  = sum[31] || (sum > LIM_H);
                o_ex.e_align = sum[0];
            end else begin
                o_ex.size    = SZ_BYTE;
                o_ex.e_addr  = sum[31] || (sum > LIM_B);
            end
            o_ex.e_zero = is_load && (i_rt_index == '0);
            ok          = !o_ex.e_addr && !o_ex.e_align && !o_ex.e_zero;
            o_ex.mem_rd = is_load && ok;
            o_ex.mem_wr = is_store && ok;
        end else if (i_kind == K_JAL) begin
            o_ex.rf_we    = 1'b1;
            o_ex.rf_waddr = REG_LINK;
        end else if (i_kind <= K_SLTI) begin
            o_ex.e_zero   = (i_rt_index == '0);
            o_ex.rf_we    = !o_ex.e_zero;
            o_ex.rf_waddr = i_rt_index;
        end
        o_ex.rf_wdata = res;
    end
endmodule
`default_nettype wire

@@ rtl/mips_subset_execute_unit.sv @@
// Top level of the MIPS subset execute unit: sequencer, register file, data memory.
`timescale 1ns / 1ps
`default_nettype none
// After reset the unit clears the register file and the data memory in a pass
// (one row of the four byte banks per cycle) with busy high. An item is accepted
// when start is high and busy is low. For ALU, branch, jump, store and flagged
// load items, both source registers are read from the register file RAMs as the
// item is accepted, then S_EXEC executes and writes back. Loads that access
// memory add S_LOAD to write back the data memory read. The result appears
// on the o_ ports with o_done high for one cycle; it is not held, and the
// receiver cannot stall it. busy is low in that same cycle, so a new item
// can be accepted then, but not while an item is in S_EXEC or S_LOAD.
module mips_subset_execute_unit
    import mseu_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          start,
    output logic         busy,
    input  wire  [4:0]   i_kind,
    input  wire  [4:0]   i_rs_index,
    input  wire  [4:0]   i_rt_index,
    input  wire  [4:0]   i_rd_index,
    input  wire  [4:0]   i_shift_amount,
    input  wire  [15:0]  i_immediate,
    input  wire  [25:0]  i_jump_target,
    input  wire  [31:0]  i_pc,
    output logic         o_done,
    output logic [31:0]  o_next_pc,
    output logic         o_write_zero_error,
    output logic         o_overflow_error,
    output logic         o_address_error,
    output logic         o_misaligned_error
);
`include "mips_subset_execute_unit_defines.svh"

    localparam int DEPTH = (MEM_BYTES + 3) / 4;
    localparam int RW    = $clog2(DEPTH);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_LOAD} t_state;

    t_state         r_state;
    logic [RW-1:0]  r_cnt;
    t_kind          r_kind;
    logic [4:0]     r_rt, r_rd, r_sh;
    logic [15:0]    r_imm;
    logic [25:0]    r_target;
    logic [31:0]    r_pc;
    logic [1:0]     r_off;

    logic [31:0] rf_a, rf_b, rf_wdata, ld_val;
    logic [4:0]  rf_waddr;
    logic        rf_we;
    t_exec       ex;

    logic [RW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    bank_q [4];
    logic [15:0]   half;

    assign busy = (r_state != S_IDLE);

    mseu_alu #(.MEM_BYTES(MEM_BYTES)) u_alu (
        .i_kind         (r_kind),
        .i_rt_index     (r_rt),
        .i_rd_index     (r_rd),
        .i_shift_amount (r_sh),
        .i_immediate    (r_imm),
        .i_jump_target  (r_target),
        .i_pc           (r_pc),
        .i_a            (rf_a),
        .i_b            (rf_b),
        .o_ex           (ex)
    );

    // register file write port, shared by clear pass, execute and load return
    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = r_cnt[4:0];
        rf_wdata = '0;
        unique case (r_state)
            S_CLEAR: rf_we = ((r_cnt >> 5) == '0);
            S_EXEC:  begin
                rf_we    = ex.rf_we;
                rf_waddr = ex.rf_waddr;
                rf_wdata = ex.rf_wdata;
            end
            S_LOAD:  begin
                rf_we    = 1'b1;
                rf_waddr = r_rt;
                rf_wdata = ld_val;
            end
            default: rf_we = 1'b0;
        endcase
    end

    // two copies so both sources are read in the same cycle
    mseu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_raddr(i_rs_index), .o_rdata(rf_a)
    );
    mseu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_raddr(i_rt_index), .o_rdata(rf_b)
    );

    assign mem_raddr = ex.addr[RW+1:2];
    assign mem_waddr = (r_state == S_CLEAR) ? r_cnt : ex.addr[RW+1:2];

    // byte bank k holds addresses with addr[1:0] == k (big-endian lanes)
    for (genvar k = 0; k < 4; k++) begin : g_bank
        localparam logic [1:0] LANE = 2'(k);
        logic       lane_we;
        logic [7:0] lane_d;

        always_comb begin
            case (ex.size)
                SZ_WORD: begin
                    lane_we = 1'b1;
                    lane_d  = rf_b[8*(3-k) +: 8];
                end
                SZ_HALF: begin
                    lane_we = (ex.addr[1] == LANE[1]);
                    lane_d  = LANE[0] ? rf_b[7:0] : rf_b[15:8];
                end
                default: begin
                    lane_we = (ex.addr[1:0] == LANE);
                    lane_d  = rf_b[7:0];
                end
            endcase
        end

        mseu_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_bank (
            .i_clk   (i_clk),
            .i_we    ((r_state == S_CLEAR) ||
                      ((r_state == S_EXEC) && ex.mem_wr && lane_we)),
            .i_waddr (mem_waddr),
            .i_wdata ((r_state == S_CLEAR) ? 8'h00 : lane_d),
            .i_raddr (mem_raddr),
            .o_rdata (bank_q[k])
        );
    end

    assign half = r_off[1] ? {bank_q[2], bank_q[3]} : {bank_q[0], bank_q[1]};

    always_comb begin
        case (r_kind)
            K_LW:    ld_val = {bank_q[0], bank_q[1], bank_q[2], bank_q[3]};
            K_LH:    ld_val = {{16{half[15]}}, half};
            K_LHU:   ld_val = {16'h0000, half};
            K_LB:    ld_val = {{24{bank_q[r_off][7]}}, bank_q[r_off]};
            default: ld_val = {24'h000000, bank_q[r_off]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == RW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_state  <= S_EXEC;
                        r_kind   <= t_kind'(i_kind);
                        r_rt     <= i_rt_index;
                        r_rd     <= i_rd_index;
                        r_sh     <= i_shift_amount;
                        r_imm    <= i_immediate;
                        r_target <= i_jump_target;
                        r_pc     <= i_pc;
                    end
                end
                S_EXEC: begin
                    o_next_pc          <= ex.next_pc;
                    o_write_zero_error <= ex.e_zero;
                    o_overflow_error   <= ex.e_ovf;
                    o_address_error    <= ex.e_addr;
                    o_misaligned_error <= ex.e_align;
                    r_off              <= ex.addr[1:0];
                    if (ex.mem_rd) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_IDLE;
                        o_done  <= 1'b1;
                    end
                end
                S_LOAD: begin
                    r_state <= S_IDLE;
                    o_done  <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `MSEU_ASSERT_NXT(a_accept_exec, start && !busy, r_state == S_EXEC, "accepted item did not execute")
    `MSEU_ASSERT_NXT(a_clear_quiet, r_state == S_CLEAR, !o_done, "result during clear pass")
    `MSEU_ASSERT_NOW(a_load_from_exec, r_state == S_LOAD, $past(r_state) == S_EXEC, "load return without execute")
    `MSEU_ASSERT_NOW(a_done_src, o_done, $past(r_state) == S_EXEC || $past(r_state) == S_LOAD, "stray result strobe")
endmodule
`default_nettype wire
